@@ hw/rtl/pair_distance_histogram_macros.svh @@
// Assertion macros for the pair distance histogram.
`ifndef PAIR_DISTANCE_HISTOGRAM_MACROS_SVH
`define PAIR_DISTANCE_HISTOGRAM_MACROS_SVH
`ifndef SYNTHESIS
`define PDH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PDH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PDH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PDH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/pdh_pkg.sv @@
`default_nettype none
package pdh_pkg;
    localparam int NBIN_DEF  = 256;
    localparam int NPAIR_DEF = 8;
    localparam int CUT_W  = 48;
    localparam int BW_W   = 24;
    localparam int D_W    = 24;
    localparam int KIND_W = 3;
    localparam int BIN_W  = 8;
    localparam int CNT_W  = 32;
    localparam int RSQ_W  = 50;
    localparam int ROOT_W = 25;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 1'b1;
    localparam logic OP_ACC  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic load;      // capture input item, start squares
        logic sum;       // add squares, compare cutoff or check read bin
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic bin_chk;   // latch bin range check, form address
        logic mem_rd;    // issue memory read
        logic mem_wr;    // write back and load output
    } pdh_cmd_t;

    typedef struct packed {
        logic is_read;
        logic sqrt_done;
        logic div_done;
        logic bin_ok;    // quotient below NBIN
        logic hit;       // checks passed: go on to the root, or to memory
    } pdh_sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/pdh_if.sv @@
`default_nettype none
interface pdh_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [pdh_pkg::D_W-1:0] dx;
    logic signed [pdh_pkg::D_W-1:0] dy;
    logic signed [pdh_pkg::D_W-1:0] dz;
    logic [pdh_pkg::KIND_W-1:0]    pair_kind;
    logic                          count_twice;
    logic [pdh_pkg::BIN_W-1:0]     read_bin;
    modport source (output valid, op, dx, dy, dz, pair_kind, count_twice, read_bin,
                    input ready);
    modport sink (input valid, op, dx, dy, dz, pair_kind, count_twice, read_bin,
                  output ready);
endinterface

interface pdh_out_if;
    logic                      valid;
    logic                      ready;
    logic                      binned;
    logic [pdh_pkg::BIN_W-1:0] bin_index;
    logic [pdh_pkg::CNT_W-1:0] bin_count;
    modport source (output valid, binned, bin_index, bin_count, input ready);
    modport sink (input valid, binned, bin_index, bin_count, output ready);
endinterface

interface pdh_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pdh_pkg::CFG_IDX_W-1:0] index;
    logic [pdh_pkg::CUT_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pair_distance_histogram.sv @@
`default_nettype none
`include "pair_distance_histogram_macros.svh"
// pair_distance_histogram
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+--------------------------------------------
//  in_ch   | in  | valid / ready | op dx dy dz pair_kind count_twice read_bin
//  out_ch  | out | valid / ready | binned bin_index bin_count
//  cfg_ch  | in  | valid / ready | index data (cutoff_sq, bin_width)
//
//  One item at a time. A binned accumulate runs through squares and cutoff check,
//  a 25-step square root and a 25-step restoring divide by bin_width (each with a
//  setup state), a range check, read and write-back. A read skips root and divide;
//  a pair outside cutoff goes straight to write-back, one past the last bin skips
//  the read. The next item can be taken in the cycle after the result is taken; a
//  stalled out_ch holds the result and the input. After reset a clearing pass zeroes
//  all NBIN*NPAIR counters, one a cycle; no item is taken meanwhile.
module pair_distance_histogram #(
    parameter int NBIN  = pdh_pkg::NBIN_DEF,
    parameter int NPAIR = pdh_pkg::NPAIR_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pdh_in_if.sink    in_ch,
    pdh_out_if.source out_ch,
    pdh_cfg_if.sink   cfg_ch
);
    localparam int DEPTH = NBIN * NPAIR;
    localparam int AW    = $clog2(DEPTH);

    logic [pdh_pkg::CUT_W-1:0] cutoff_sq_reg;
    logic [pdh_pkg::BW_W-1:0]  bin_width_reg;
    logic [AW:0]               clr_cnt_reg;
    logic                      clr_busy;
    logic                      ctrl_in_ready;
    pdh_pkg::pdh_cmd_t         cmd;
    pdh_pkg::pdh_sts_t         sts;

    // Clearing pass: one counter per cycle until the count reaches DEPTH.
    assign clr_busy = (clr_cnt_reg != (AW+1)'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            cutoff_sq_reg <= '0;
            bin_width_reg <= pdh_pkg::BW_W'(65536);
        end
        else
        begin
            if (clr_busy)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_ch.valid)
            begin
                unique case (cfg_ch.index)
                    pdh_pkg::REG_CUTOFF_SQ: cutoff_sq_reg <= cfg_ch.data;
                    pdh_pkg::REG_BIN_WIDTH:
                        bin_width_reg <= cfg_ch.data[pdh_pkg::BW_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = ctrl_in_ready && !clr_busy;

    pdh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid && !clr_busy),
        .in_ready  (ctrl_in_ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pdh_dp #(.NBIN(NBIN), .NPAIR(NPAIR)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .clr_busy    (clr_busy),
        .cutoff_sq   (cutoff_sq_reg),
        .bin_width   (bin_width_reg),
        .op          (in_ch.op),
        .dx          (in_ch.dx),
        .dy          (in_ch.dy),
        .dz          (in_ch.dz),
        .pair_kind   (in_ch.pair_kind),
        .count_twice (in_ch.count_twice),
        .read_bin    (in_ch.read_bin),
        .clr_we      (clr_busy),
        .clr_addr    (clr_cnt_reg[AW-1:0]),
        .binned      (out_ch.binned),
        .bin_index   (out_ch.bin_index),
        .bin_count   (out_ch.bin_count)
    );

    // No item accepted during the clearing pass.
    `PDH_ASSERT_IMPL(a_no_accept_clr, clk, rst_n, clr_busy, !in_ch.ready)
    // Hold off input while a result waits.
    `PDH_ASSERT_IMPL(a_ready_excl, clk, rst_n, out_ch.valid, !in_ch.ready)
    // Write-back raises valid on the next edge.
    `PDH_ASSERT_NEXT(a_wr_valid, clk, rst_n, cmd.mem_wr, out_ch.valid)
endmodule
`default_nettype wire

@@ hw/rtl/pdh_ctrl.sv @@
`default_nettype none
module pdh_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire pdh_pkg::pdh_sts_t sts,
    output pdh_pkg::pdh_cmd_t      cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SUM, S_DEC, S_SQRT_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_RD, S_WR,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Busy until the result is taken; one item at a time.
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                // squares register at the end of this cycle
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (sts.is_read)
                begin
                    state_next = sts.hit ? S_RD : S_WR;
                end
                else
                begin
                    state_next = sts.hit ? S_SQRT_INIT : S_WR;
                end
            end
            S_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_done)
                begin
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.bin_chk = 1'b1;
                state_next  = sts.bin_ok ? S_RD : S_WR;
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.mem_wr     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/pdh_dp.sv @@
`default_nettype none
module pdh_dp #(
    parameter int NBIN  = pdh_pkg::NBIN_DEF,
    parameter int NPAIR = pdh_pkg::NPAIR_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pdh_pkg::pdh_cmd_t             cmd,
    output pdh_pkg::pdh_sts_t                  sts,
    input  wire logic                          clr_busy,
    input  wire logic [pdh_pkg::CUT_W-1:0]     cutoff_sq,
    input  wire logic [pdh_pkg::BW_W-1:0]      bin_width,
    input  wire logic                          op,
    input  wire logic signed [pdh_pkg::D_W-1:0] dx,
    input  wire logic signed [pdh_pkg::D_W-1:0] dy,
    input  wire logic signed [pdh_pkg::D_W-1:0] dz,
    input  wire logic [pdh_pkg::KIND_W-1:0]    pair_kind,
    input  wire logic                          count_twice,
    input  wire logic [pdh_pkg::BIN_W-1:0]     read_bin,
    input  wire logic                          clr_we,
    input  wire logic [$clog2(NBIN*NPAIR)-1:0] clr_addr,
    output logic                               binned,
    output logic [pdh_pkg::BIN_W-1:0]          bin_index,
    output logic [pdh_pkg::CNT_W-1:0]          bin_count
);
    localparam int DEPTH  = NBIN * NPAIR;
    localparam int AW     = $clog2(DEPTH);
    localparam int MAG_W  = pdh_pkg::D_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int RSQ_W  = pdh_pkg::RSQ_W;
    localparam int ROOT_W = pdh_pkg::ROOT_W;
    localparam int SCNT_W = $clog2(ROOT_W + 1);
    localparam int DCNT_W = $clog2(ROOT_W + 1);
    localparam int CNT_W  = pdh_pkg::CNT_W;
    localparam logic [AW-1:0] NBIN_A = AW'(NBIN);

    logic                  op_reg, twice_reg;
    logic [pdh_pkg::KIND_W-1:0] kind_reg;
    logic [pdh_pkg::BIN_W-1:0]  rbin_reg;
    logic [MAG_W-1:0]      mx_reg, my_reg, mz_reg;
    logic [SQ_W-1:0]       sx_reg, sy_reg, sz_reg;
    logic [RSQ_W-1:0]      rsq_reg;
    logic                  hit_reg;
    logic [RSQ_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SCNT_W-1:0]     scnt_reg;
    logic [ROOT_W-1:0]     quo_reg;
    logic [pdh_pkg::BW_W:0] drem_reg;
    logic [DCNT_W-1:0]     dcnt_reg;
    logic [AW-1:0]         addr_reg;
    logic [CNT_W-1:0]      rdata_reg;
    logic [CNT_W-1:0]      mem [DEPTH];
    logic                  binned_reg;
    logic [pdh_pkg::BIN_W-1:0] idx_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic                  kind_ok;
    logic                  bin_ok;
    logic [AW-1:0]         kind_base;
    logic [RSQ_W-1:0]      rsq_sum;
    logic [RSQ_W+1:0]      trial;
    logic [pdh_pkg::BW_W:0] dtrial;
    logic [CNT_W:0]        inc;
    logic [CNT_W-1:0]      upd;

    function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
        logic [MAG_W-1:0] u;
        u = v;
        return v[MAG_W-1] ? (~u + 1'b1) : u;
    endfunction

    assign kind_ok = ({1'b0, kind_reg} < (pdh_pkg::KIND_W+1)'(NPAIR))
                     || (NPAIR > 7);
    assign rsq_sum = RSQ_W'(sx_reg) + RSQ_W'(sy_reg) + RSQ_W'(sz_reg);
    assign bin_ok  = (quo_reg < ROOT_W'(NBIN));
    // First counter of this pair kind.
    assign kind_base = AW'(kind_reg) * NBIN_A;

    // One step of the restoring square root (one root bit, two radicand bits per cycle).
    assign trial = {rem_reg, rsq_reg[RSQ_W-1 -: 2]} - {root_reg, 2'b01};
    // One step of restoring division of root by bin_width.
    assign dtrial = {drem_reg[pdh_pkg::BW_W-1:0], quo_reg[ROOT_W-1]} - {1'b0, bin_width};

    assign inc = {1'b0, rdata_reg} + (twice_reg ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
    assign upd = inc[CNT_W] ? '1 : inc[CNT_W-1:0];

    assign sts.is_read   = op_reg;
    assign sts.sqrt_done = (scnt_reg == SCNT_W'(1));
    assign sts.div_done  = (dcnt_reg == DCNT_W'(1));
    assign sts.bin_ok    = bin_ok;
    assign sts.hit       = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            scnt_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cmd.sum)
            begin
                if (op_reg)
                begin
                    hit_reg <= kind_ok && ({1'b0, rbin_reg} < (pdh_pkg::BIN_W+1)'(NBIN)
                               || NBIN > 255);
                end
                else
                begin
                    hit_reg <= kind_ok && (bin_width != '0)
                               && (rsq_sum < RSQ_W'(cutoff_sq));
                end
            end
            if (cmd.sqrt_init)
            begin
                scnt_reg <= SCNT_W'(RSQ_W / 2);
            end
            else if (cmd.sqrt_step)
            begin
                scnt_reg <= scnt_reg - 1'b1;
            end
            if (cmd.div_init)
            begin
                dcnt_reg <= DCNT_W'(ROOT_W);
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            if (cmd.bin_chk)
            begin
                hit_reg <= bin_ok;
            end
            if (cmd.mem_wr)
            begin
                hit_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            twice_reg <= count_twice;
            kind_reg  <= pair_kind;
            rbin_reg  <= read_bin;
            mx_reg    <= mag(dx);
            my_reg    <= mag(dy);
            mz_reg    <= mag(dz);
            binned_reg <= 1'b0;
        end
        sx_reg <= mx_reg * mx_reg;
        sy_reg <= my_reg * my_reg;
        sz_reg <= mz_reg * mz_reg;
        if (cmd.sum)
        begin
            rsq_reg  <= rsq_sum;
            addr_reg <= kind_base + AW'(rbin_reg);
        end
        if (cmd.sqrt_init)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (!trial[RSQ_W+1])
            begin
                rem_reg  <= trial[RSQ_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[RSQ_W-3:0], rsq_reg[RSQ_W-1 -: 2]};
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
            rsq_reg <= {rsq_reg[RSQ_W-3:0], 2'b00};
        end
        if (cmd.div_init)
        begin
            quo_reg  <= root_reg;
            drem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!dtrial[pdh_pkg::BW_W])
            begin
                drem_reg <= dtrial;
                quo_reg  <= {quo_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[pdh_pkg::BW_W-1:0], quo_reg[ROOT_W-1]};
                quo_reg  <= {quo_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.bin_chk)
        begin
            // quotient ready: hold the bin and its counter address
            rbin_reg <= quo_reg[pdh_pkg::BIN_W-1:0];
            addr_reg <= kind_base + AW'(quo_reg);
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[addr_reg];
        end
        if (cmd.mem_wr)
        begin
            if (hit_reg && op_reg)
            begin
                cnt_reg <= rdata_reg;
                idx_reg <= rbin_reg;
            end
            else if (hit_reg)
            begin
                cnt_reg    <= upd;
                idx_reg    <= rbin_reg;
                binned_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
                idx_reg <= op_reg ? rbin_reg : '0;
            end
        end
    end

    // Memory write: clearing sweep or item write-back.
    always_ff @(posedge clk)
    begin
        if (clr_busy)
        begin
            if (clr_we)
            begin
                mem[clr_addr] <= '0;
            end
        end
        else if (cmd.mem_wr && hit_reg)
        begin
            mem[addr_reg] <= op_reg ? '0 : upd;
        end
    end

    assign binned    = binned_reg;
    assign bin_index = idx_reg;
    assign bin_count = cnt_reg;
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

typedef struct {
    logic        op;
    logic [23:0] dx;
    logic [23:0] dy;
    logic [23:0] dz;
    logic [2:0]  kind;
    logic        twice;
    logic [7:0]  rbin;
} pair_item_t;

typedef struct {
    logic        binned;
    logic [7:0]  idx;
    logic [31:0] cnt;
} bin_result_t;

// Expected-result store and histogram predictor.
// Holds its own copy of the counters and of the two registers.
class hist_scoreboard;
    logic [47:0] cutoff_sq;
    logic [23:0] bin_width;
    logic [31:0] counts [8][256];
    bin_result_t expected_bins [$];
    int          mismatches;

    function new();
        cutoff_sq = '0;
        bin_width = 24'd65536;
        mismatches = 0;
        foreach (counts[k, b])
            counts[k][b] = '0;
    endfunction

    function void write_reg(logic idx, logic [47:0] value);
        if (idx == pdh_pkg::REG_CUTOFF_SQ)
            cutoff_sq = value;
        else
            bin_width = value[23:0];
    endfunction

    // Magnitude squared of a 24-bit two's complement value.
    function longint unsigned axis_sq(logic [23:0] raw);
        longint unsigned mag;
        mag = raw[23] ? (longint'(25'h1000000) - longint'(raw)) : longint'(raw);
        return mag * mag;
    endfunction

    // Floor square root, built one result bit at a time from the top.
    function longint unsigned floor_root(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = 25; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function void note_item(pair_item_t it);
        bin_result_t     r;
        longint unsigned rsq;
        longint unsigned bin;
        longint unsigned c;
        r = '{1'b0, 8'd0, 32'd0};
        if (it.op == pdh_pkg::OP_READ)
        begin
            r.idx = it.rbin;
            r.cnt = counts[it.kind][it.rbin];
            counts[it.kind][it.rbin] = '0;
        end
        else
        begin
            rsq = axis_sq(it.dx) + axis_sq(it.dy) + axis_sq(it.dz);
            if (bin_width != 0 && rsq < cutoff_sq)
            begin
                bin = floor_root(rsq) / bin_width;
                if (bin < 256)
                begin
                    c = counts[it.kind][bin] + (it.twice ? 2 : 1);
                    if (c > 64'hFFFF_FFFF)
                        c = 64'hFFFF_FFFF;
                    counts[it.kind][bin] = c[31:0];
                    r = '{1'b1, bin[7:0], c[31:0]};
                end
            end
        end
        expected_bins.push_back(r);
    endfunction

    function void check_result(bin_result_t got);
        bin_result_t want;
        if (expected_bins.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with nothing expected: binned=%0d idx=%0d cnt=%0d",
                         got.binned, got.idx, got.cnt);
            return;
        end
        want = expected_bins.pop_front();
        if (got.binned !== want.binned || got.idx !== want.idx || got.cnt !== want.cnt)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: expected binned=%0d idx=%0d cnt=%0d, %s%0d idx=%0d cnt=%0d",
                         want.binned, want.idx, want.cnt, "got binned=",
                         got.binned, got.idx, got.cnt);
        end
    endfunction

    function int pending();
        return expected_bins.size();
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;

    pdh_in_if  in_ch ();
    pdh_out_if out_ch ();
    pdh_cfg_if cfg_ch ();

    pair_distance_histogram u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    hist_scoreboard hist_sb;

    // Idling control shared by both sides; hold_off forces a long receiver stall.
    bit no_idle;
    int hold_off;

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // Give up after a generous fixed time: clearing pass plus slow items several times over.
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // Receiver: check every accepted result, stall at random or for a forced stretch.
    initial
    begin
        bin_result_t got;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.binned, out_ch.bin_index, out_ch.bin_count};
                hist_sb.check_result(got);
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 33);
        end
    end

    // Write one register; the block must be idle.
    task automatic write_reg(logic idx, logic [47:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        hist_sb.write_reg(idx, value);
        cfg_ch.valid <= 1'b0;
    endtask

    // Offer one item, hold it until taken, then maybe drop valid for a gap.
    task automatic send_item(pair_item_t it);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.op          <= it.op;
        in_ch.dx          <= it.dx;
        in_ch.dy          <= it.dy;
        in_ch.dz          <= it.dz;
        in_ch.pair_kind   <= it.kind;
        in_ch.count_twice <= it.twice;
        in_ch.read_bin    <= it.rbin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        hist_sb.note_item(it);
        if (!no_idle && $urandom_range(0, 99) < 33)
        begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_acc(logic [23:0] dx, logic [23:0] dy, logic [23:0] dz,
                            logic [2:0] kind, logic twice);
        send_item('{pdh_pkg::OP_ACC, dx, dy, dz, kind, twice, 8'($urandom)});
    endtask

    task automatic send_read(logic [2:0] kind, logic [7:0] rbin);
        send_item('{pdh_pkg::OP_READ, 24'($urandom), 24'($urandom), 24'($urandom),
                    kind, 1'b0, rbin});
    endtask

    // Displacement of random scale so that bins across the range get hit.
    function automatic logic [23:0] rand_axis();
        int          scale;
        logic [23:0] v;
        scale = $urandom_range(0, 23);
        v = 24'($urandom) & ((24'd1 << scale) - 1);
        if ($urandom_range(0, 1))
            v = -v;
        if ($urandom_range(0, 30) == 0)
            v = 24'($urandom);
        return v;
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 25)
                send_read(3'($urandom),
                          $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom));
            else
                send_acc(rand_axis(), rand_axis(), rand_axis(), 3'($urandom),
                         1'($urandom));
        end
    endtask

    // Drop valid and wait for every outstanding result, then let the block settle.
    task automatic drain();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (hist_sb.pending() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    initial
    begin
        logic [47:0] cut_list [7];
        logic [47:0] bw_list [7];
        hist_sb  = new();
        no_idle  = 1'b0;
        hold_off = 0;
        rst_n <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= pdh_pkg::OP_ACC;
        in_ch.dx          <= '0;
        in_ch.dy          <= '0;
        in_ch.dz          <= '0;
        in_ch.pair_kind   <= '0;
        in_ch.count_twice <= 1'b0;
        in_ch.read_bin    <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= pdh_pkg::REG_CUTOFF_SQ;
        cfg_ch.data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset cutoff of zero rejects everything.
        send_acc(24'd0, 24'd0, 24'd0, 3'd0, 1'b0);
        send_acc(24'd65536, 24'd0, 24'd0, 3'd1, 1'b1);
        drain();

        write_reg(pdh_pkg::REG_CUTOFF_SQ, 48'hFFFF_FFFF_FFFF);
        // Zero distance, both extremes of each axis, double counting, top pair kind.
        send_acc(24'd0, 24'd0, 24'd0, 3'd0, 1'b0);
        send_acc(24'd0, 24'd0, 24'd0, 3'd0, 1'b1);
        send_acc(24'h7FFFFF, 24'd0, 24'd0, 3'd7, 1'b0);
        send_acc(24'd0, 24'h7FFFFF, 24'd0, 3'd7, 1'b1);
        send_acc(24'd0, 24'd0, 24'h800000, 3'd3, 1'b0);
        send_acc(24'h800000, 24'h800000, 24'h800000, 3'd7, 1'b1);
        send_acc(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 3'd2, 1'b0);
        send_acc(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 3'd5, 1'b0);
        send_acc(24'd131071, 24'd0, 24'd0, 3'd4, 1'b0);
        send_acc(24'd131072, 24'd0, 24'd0, 3'd4, 1'b1);
        // Read back and clear, then read the cleared bin again; top read bin too.
        send_read(3'd0, 8'd0);
        send_read(3'd0, 8'd0);
        send_read(3'd7, 8'd127);
        send_read(3'd7, 8'd221);
        send_read(3'd4, 8'd1);
        send_read(3'd4, 8'd2);
        send_read(3'd6, 8'd255);
        drain();

        // Bin width zero: nothing counted.
        write_reg(pdh_pkg::REG_BIN_WIDTH, 48'd0);
        send_acc(24'd0, 24'd0, 24'd0, 3'd0, 1'b0);
        send_acc(24'd100, 24'd5, 24'd0, 3'd1, 1'b0);
        drain();
        // Narrowest width: distances beyond 255 raw units fall past the last bin.
        write_reg(pdh_pkg::REG_BIN_WIDTH, 48'd1);
        send_acc(24'd255, 24'd0, 24'd0, 3'd2, 1'b0);
        send_acc(24'd256, 24'd0, 24'd0, 3'd2, 1'b0);
        send_read(3'd2, 8'd255);
        drain();

        // Random phases across register settings, extremes included.
        cut_list = '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0100_0000_0000,
                     48'd0, 48'hFFFF_FFFF_FFFF, 48'($urandom) << 16, 48'h0040_0000_0000};
        bw_list  = '{48'd65536, 48'd1, 48'hFFFF_FFFF_FFFF, 48'd65536, 48'd0,
                     48'($urandom_range(1, 1 << 20)), 48'd4096};
        for (int p = 0; p < 7; p++)
        begin
            write_reg(pdh_pkg::REG_CUTOFF_SQ, cut_list[p]);
            write_reg(pdh_pkg::REG_BIN_WIDTH, bw_list[p]);
            if (p == 2)
            begin
                // Stall the receiver for a long stretch while items keep coming.
                no_idle  = 1'b1;
                hold_off = 400;
            end
            if (p == 4)
                no_idle = 1'b0;
            send_random(95);
            drain();
        end

        // Leftover expectations count as failures.
        hist_sb.mismatches += hist_sb.pending();
        if (hist_sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire

@@ pair_distance_histogram.f @@
+incdir+hw/rtl
hw/rtl/pdh_pkg.sv
hw/rtl/pdh_if.sv
hw/rtl/pdh_ctrl.sv
hw/rtl/pdh_dp.sv
hw/rtl/pair_distance_histogram.sv
tb/tb.sv
